FILE: hdl/bce_pkg.sv
// Shared constants and register codes for the 3x3 binary erosion block.
package bce_pkg;

    localparam int PIX_W       = 8;
    localparam int ROW_OUT_W   = 12;
    localparam int COL_OUT_W   = 10;
    localparam int MASK_W      = 9;
    localparam int IMG_W_W     = 11;
    localparam int IMG_H_W     = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int OUT_DATA_W  = 32;

    localparam logic [PIX_W-1:0] PIX_SET = 8'd255;
    localparam logic [PIX_W-1:0] PIX_CLR = 8'd0;

    localparam logic [MASK_W-1:0]  RST_KERNEL_MASK  = 9'd511;
    localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [IMG_H_W-1:0] RST_IMAGE_HEIGHT = 13'd480;

    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_MASK  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

endpackage

FILE: hdl/bce_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bce_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/binary_erosion_3x3.sv
// Top level of the streaming 3x3 binary erosion block.
//
// Pixels enter on the s_axis channel in raster order, one 8-bit pixel per
// transfer; a pixel counts as set only when it is 255. Results leave on the
// m_axis channel, one per interior pixel (rows 1..height-2, cols 1..width-2):
// tdata carries the centre row, centre column and eroded value (255 or 0),
// tlast marks the last interior result of the frame. Border pixels give no
// transfer. The geometry and the 9-bit structuring mask are written through
// the cfg port; the user must do so only while the block is idle (not enforced).
// Throughput is one pixel per cycle while the receiver does not stall: the
// two previous rows live in a single 2-bit wide line RAM that is read at the
// pixel's column on accept and written back when the item leaves stage 1,
// so each column is read once and written once per row.
// An input transfer's result passes through stage 1 (RAM read) and then the
// output register. A stalled receiver holds the output register; the input
// keeps accepting while the pipeline stage behind it can still move.
// Reset (synchronous, active low) clears the counters, the window and the
// valids, and loads mask 511, width 640, height 480. The line RAM is not
// cleared; the first two rows of a frame never produce results from it.
module binary_erosion_3x3
    import bce_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [PIX_W-1:0]       s_axis_tdata,  // [7:0] pixel_value
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [11:0] centre_row, [21:12] centre_col, [29:22] eroded_value, [31:30] zero
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                   m_axis_tlast   // frame_done
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WCW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
    localparam int HCW = (RW + 1 > IMG_H_W) ? RW + 1 : IMG_H_W;
    localparam int PADW = OUT_DATA_W - ROW_OUT_W - COL_OUT_W - PIX_W;

    // configuration registers
    logic [MASK_W-1:0]  r_kernel_mask;
    logic [IMG_W_W-1:0] r_image_width;
    logic [IMG_H_W-1:0] r_image_height;

    // input side counters
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    // stage 1: waits for the line RAM read
    logic          r_s1_valid;
    logic          r_s1_bot;
    logic [CW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;

    logic [MASK_W-1:0] r_window, n_window;

    // output register
    logic                 r_out_valid;
    logic [ROW_OUT_W-1:0] r_out_row;
    logic [COL_OUT_W-1:0] r_out_col;
    logic [PIX_W-1:0]     r_out_value;
    logic                 r_out_last;

    logic [WCW-1:0] w_clamp;
    logic [HCW-1:0] h_clamp;
    logic           in_accept;
    logic           s1_adv;
    logic           bot;
    logic [1:0]     ram_rd_data;
    logic [1:0]     ram_wr_data;
    logic [WCW-1:0] col_ext, s1_col_ext;
    logic [HCW-1:0] row_ext, s1_row_ext;
    logic           emit, hit, last;
    logic [ROW_OUT_W-1:0] row_m1;
    logic [COL_OUT_W-1:0] col_m1;

    // clamp geometry to the supported range
    always_comb begin
        if (WCW'(r_image_width) < WCW'(3)) begin
            w_clamp = WCW'(3);
        end else if (WCW'(r_image_width) > WCW'(MAX_WIDTH)) begin
            w_clamp = WCW'(MAX_WIDTH);
        end else begin
            w_clamp = WCW'(r_image_width);
        end
        if (HCW'(r_image_height) < HCW'(3)) begin
            h_clamp = HCW'(3);
        end else if (HCW'(r_image_height) > HCW'(MAX_HEIGHT)) begin
            h_clamp = HCW'(MAX_HEIGHT);
        end else begin
            h_clamp = HCW'(r_image_height);
        end
    end

    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign bot           = (s_axis_tdata == PIX_SET);

    // raster counters; wrap also when a shrunk geometry is already passed
    assign col_ext = WCW'(r_col);
    assign row_ext = HCW'(r_row);
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_ext + WCW'(1) >= w_clamp) begin
            n_col = '0;
            n_row = (row_ext + HCW'(1) >= h_clamp) ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    // line RAM: bit 0 = upper row, bit 1 = middle row.
    // Consecutive items always differ in column, so a read never meets the
    // write-back of the item ahead of it.
    assign ram_wr_data = {r_s1_bot, ram_rd_data[1]};

    bce_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (r_col),
        .o_rd_data (ram_rd_data)
    );

    // shift window left, new column enters at col 2 (top, mid, bottom)
    always_comb begin
        n_window      = r_window;
        n_window[1:0] = r_window[2:1];
        n_window[4:3] = r_window[5:4];
        n_window[7:6] = r_window[8:7];
        n_window[2]   = ram_rd_data[0];
        n_window[5]   = ram_rd_data[1];
        n_window[8]   = r_s1_bot;
    end

    assign s1_col_ext = WCW'(r_s1_col);
    assign s1_row_ext = HCW'(r_s1_row);
    assign hit  = (n_window & r_kernel_mask) == r_kernel_mask;
    assign emit = (s1_row_ext >= HCW'(2)) && (s1_col_ext >= WCW'(2))
                  && (s1_row_ext < h_clamp) && (s1_col_ext < w_clamp);
    assign last = (s1_row_ext + HCW'(1) == h_clamp) && (s1_col_ext + WCW'(1) == w_clamp);
    assign row_m1 = ROW_OUT_W'(r_s1_row) - ROW_OUT_W'(1);
    assign col_m1 = COL_OUT_W'(r_s1_col) - COL_OUT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_mask  <= RST_KERNEL_MASK;
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_KERNEL_MASK:  r_kernel_mask  <= i_cfg_wdata[MASK_W-1:0];
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wdata[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_wdata[IMG_H_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_window    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_window    <= n_window;
                r_out_valid <= emit;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_bot <= bot;
            r_s1_col <= r_col;
            r_s1_row <= r_row;
        end
        if (s1_adv) begin
            r_out_row   <= row_m1;
            r_out_col   <= col_m1;
            r_out_value <= hit ? PIX_SET : PIX_CLR;
            r_out_last  <= last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PADW{1'b0}}, r_out_value, r_out_col, r_out_row};
    assign m_axis_tlast  = r_out_last;

    // a new read never targets the column whose write-back is still pending
    a_no_ram_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && r_s1_valid |-> r_col != r_s1_col)
        else $error("line RAM read collides with pending write-back");

    // a stage 1 item that cannot move keeps its column
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_col))
        else $error("stage 1 item lost while stalled");

    a_value_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_value == PIX_SET || r_out_value == PIX_CLR))
        else $error("eroded value is neither set nor clear");

endmodule
